@@ hdl/ftsr_pkg.sv @@
// Package for the flight-triggered sample recorder.
// Holds register indexes, opcodes, state codes and the structs shared between modules.
// No dependencies.
package ftsr_pkg;

    localparam int unsigned BUFFER_ENTRIES_DEF = 256;
    localparam int unsigned BYTES_PER_SAMPLE   = 4;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MULT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE_BYTES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES     = 3'd4;

    localparam logic [15:0] RST_OVERSAMPLE_COUNT = 16'd500;
    localparam logic [15:0] RST_SCALE_MULT       = 16'd16384;
    localparam logic [4:0]  RST_SCALE_SHIFT      = 5'd16;
    localparam logic [24:0] RST_FILE_SIZE_BYTES  = 25'd1048576;
    localparam logic [7:0]  RST_HEADER_BYTES     = 8'd16;

    localparam logic [1:0] OP_RAW_SAMPLE = 2'd0;
    localparam logic [1:0] OP_FLIGHT     = 2'd1;
    localparam logic [1:0] OP_SAVE_DONE  = 2'd2;

    localparam logic [1:0] REC_READY      = 2'd0;
    localparam logic [1:0] REC_RECORDING  = 2'd1;
    localparam logic [1:0] REC_FINALIZING = 2'd2;
    localparam logic [1:0] REC_FINALIZED  = 2'd3;

    localparam logic [3:0] PH_STARTUP = 4'd0;
    localparam logic [3:0] PH_IDLE    = 4'd1;
    localparam logic [3:0] PH_PAD     = 4'd2;
    localparam logic [3:0] PH_BOOST   = 4'd3;
    localparam logic [3:0] PH_LANDED  = 4'd8;

    typedef struct packed {
        logic [15:0] oversample_count;
        logic [15:0] scale_mult;
        logic [4:0]  scale_shift;
        logic [24:0] file_size_bytes;
        logic [7:0]  header_bytes;
    } t_cfg;

    typedef struct packed {
        logic        sample_ready;
        logic [31:0] sum;
        logic [15:0] tick;
        logic        bank;
        logic [7:0]  slot;
        logic        save_request;
        logic        overrun;
        logic [1:0]  record_state;
        logic        finalize_request;
        logic [15:0] final_sample_count;
        logic        reset_request;
    } t_mid;

endpackage

@@ hdl/ftsr_in_if.sv @@
// Input channel of the recorder: valid/ready plus one input item.
// No dependencies.
interface ftsr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] adc_sample;
    logic [3:0]  flight_phase;
    logic [15:0] flight_tick;

    modport source (output valid, output opcode, output adc_sample, output flight_phase,
                    output flight_tick, input ready);
    modport sink (input valid, input opcode, input adc_sample, input flight_phase,
                  input flight_tick, output ready);
endinterface

@@ hdl/ftsr_out_if.sv @@
// Result channel of the recorder: valid/ready plus one result item.
// No dependencies.
interface ftsr_out_if;
    logic        valid;
    logic        ready;
    logic        sample_ready;
    logic [15:0] sample_value;
    logic [15:0] sample_tick;
    logic        sample_bank;
    logic [7:0]  sample_slot;
    logic        save_request;
    logic        overrun;
    logic [1:0]  record_state;
    logic        finalize_request;
    logic [15:0] final_sample_count;
    logic        reset_request;

    modport source (output valid, output sample_ready, output sample_value, output sample_tick,
                    output sample_bank, output sample_slot, output save_request,
                    output overrun, output record_state, output finalize_request,
                    output final_sample_count, output reset_request, input ready);
    modport sink (input valid, input sample_ready, input sample_value, input sample_tick,
                  input sample_bank, input sample_slot, input save_request,
                  input overrun, input record_state, input finalize_request,
                  input final_sample_count, input reset_request, output ready);
endinterface

@@ hdl/ftsr_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// No dependencies.
interface ftsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [24:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/ftsr_cfg_regs.sv @@
// Configuration register file of the recorder.
// Depends on ftsr_pkg and ftsr_cfg_if.
module ftsr_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ftsr_cfg_if.sink      i_cfg,
    output ftsr_pkg::t_cfg o_cfg
);
    import ftsr_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.oversample_count <= RST_OVERSAMPLE_COUNT;
            r_cfg.scale_mult       <= RST_SCALE_MULT;
            r_cfg.scale_shift      <= RST_SCALE_SHIFT;
            r_cfg.file_size_bytes  <= RST_FILE_SIZE_BYTES;
            r_cfg.header_bytes     <= RST_HEADER_BYTES;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_OVERSAMPLE_COUNT: r_cfg.oversample_count <= i_cfg.data[15:0];
                CFG_SCALE_MULT:       r_cfg.scale_mult       <= i_cfg.data[15:0];
                CFG_SCALE_SHIFT:      r_cfg.scale_shift      <= i_cfg.data[4:0];
                CFG_FILE_SIZE_BYTES:  r_cfg.file_size_bytes  <= i_cfg.data[24:0];
                CFG_HEADER_BYTES:     r_cfg.header_bytes     <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hdl/ftsr_state.sv @@
// Input register and state update of the recorder: oversampling, buffer slots,
// recording state machine and file offset. Depends on ftsr_pkg and ftsr_in_if.
module ftsr_state #(
    parameter int unsigned BUFFER_ENTRIES = ftsr_pkg::BUFFER_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ftsr_in_if.sink        i_in,
    input  ftsr_pkg::t_cfg i_cfg,
    input  logic           i_next_adv,
    output logic           o_mid_valid,
    output ftsr_pkg::t_mid o_mid
);
    import ftsr_pkg::*;

    localparam int unsigned SLOT_W = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUFFER_ENTRIES - 1);
    localparam logic [25:0] BUF_BYTES = 26'(BUFFER_ENTRIES * BYTES_PER_SAMPLE);

    logic              r_in_valid;
    logic [1:0]        r_op;
    logic [11:0]       r_adc;
    logic [3:0]        r_fs;
    logic [15:0]       r_tick;

    logic [31:0]       r_sum, n_sum;
    logic [15:0]       r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_bank, n_bank;
    logic              r_save_pend, n_save_pend;
    logic [1:0]        r_rec, n_rec;
    logic [3:0]        r_last_fs, n_last_fs;
    logic [15:0]       r_latest_tick, n_latest_tick;
    logic [24:0]       r_offset, n_offset;
    logic              r_rst_pend, n_rst_pend;

    logic              r_mid_valid;
    t_mid              r_mid, n_mid;

    logic              adv_mid, adv_in, step;
    logic [15:0]       need;
    logic [31:0]       sum_add;
    logic [15:0]       cnt_inc;
    logic [25:0]       off_sum, new_off_sum;
    logic [24:0]       off_diff;
    logic [SLOT_W+7:0] slot_ext;

    assign adv_mid     = !r_mid_valid || i_next_adv;
    assign adv_in      = !r_in_valid || adv_mid;
    assign step        = r_in_valid && adv_mid;
    assign i_in.ready  = adv_in;
    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

    always_comb begin
        n_sum         = r_sum;
        n_cnt         = r_cnt;
        n_slot        = r_slot;
        n_bank        = r_bank;
        n_save_pend   = r_save_pend;
        n_rec         = r_rec;
        n_last_fs     = r_last_fs;
        n_latest_tick = r_latest_tick;
        n_offset      = r_offset;
        n_rst_pend    = r_rst_pend;
        n_mid         = '0;

        need        = (i_cfg.oversample_count == 16'd0) ? 16'd1 : i_cfg.oversample_count;
        sum_add     = r_sum + {20'd0, r_adc};
        cnt_inc     = r_cnt + 16'd1;
        slot_ext    = {8'd0, r_slot};
        off_sum     = {1'b0, r_offset} + BUF_BYTES;
        new_off_sum = '0;
        off_diff    = '0;

        case (r_op)
            OP_RAW_SAMPLE: begin
                n_sum = sum_add;
                n_cnt = cnt_inc;
                if (cnt_inc >= need) begin
                    n_mid.sample_ready = 1'b1;
                    n_mid.sum          = sum_add;
                    n_mid.tick         = r_latest_tick;
                    n_mid.bank         = r_bank;
                    n_mid.slot         = slot_ext[7:0];
                    n_sum              = '0;
                    n_cnt              = '0;
                    if (r_slot == SLOT_LAST) begin
                        n_slot = '0;
                        n_bank = ~r_bank;
                        if (r_rec == REC_RECORDING || r_rec == REC_FINALIZING) begin
                            n_mid.overrun      = r_save_pend;
                            n_mid.save_request = 1'b1;
                            n_save_pend        = 1'b1;
                        end
                    end else begin
                        n_slot = r_slot + SLOT_W'(1);
                    end
                end
            end
            OP_FLIGHT: begin
                n_latest_tick = r_tick;
                n_last_fs     = r_fs;
                if (r_fs != r_last_fs) begin
                    if (r_fs == PH_STARTUP) begin
                        n_rst_pend = 1'b1;
                    end else if (r_fs == PH_IDLE || r_fs == PH_PAD) begin
                        n_rec = REC_READY;
                    end else if (r_fs == PH_BOOST) begin
                        if (r_last_fs == PH_PAD && r_rec == REC_READY) begin
                            n_rec = REC_RECORDING;
                        end
                    end else if (r_fs <= PH_LANDED) begin
                        if (r_rec == REC_RECORDING) begin
                            n_rec = REC_FINALIZING;
                        end
                    end
                end
            end
            OP_SAVE_DONE: begin
                if (r_save_pend) begin
                    n_save_pend = 1'b0;
                    if (off_sum <= {1'b0, i_cfg.file_size_bytes}) begin
                        n_offset = off_sum[24:0];
                    end
                    new_off_sum = {1'b0, n_offset} + BUF_BYTES;
                    off_diff    = n_offset - {17'd0, i_cfg.header_bytes};
                    if (r_rec == REC_FINALIZING) begin
                        n_mid.finalize_request = 1'b1;
                        if (n_offset >= {17'd0, i_cfg.header_bytes}) begin
                            n_mid.final_sample_count = off_diff[17:2];
                        end
                        n_rec = REC_FINALIZED;
                    end else if (r_rec == REC_RECORDING &&
                                 new_off_sum >= {1'b0, i_cfg.file_size_bytes}) begin
                        n_rec = REC_FINALIZING;
                    end
                end
            end
            default: begin
            end
        endcase

        n_mid.record_state  = n_rec;
        n_mid.reset_request = n_rst_pend && n_rec != REC_RECORDING &&
                              n_rec != REC_FINALIZING;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_mid_valid   <= 1'b0;
            r_sum         <= '0;
            r_cnt         <= '0;
            r_slot        <= '0;
            r_bank        <= 1'b0;
            r_save_pend   <= 1'b0;
            r_rec         <= REC_READY;
            r_last_fs     <= PH_STARTUP;
            r_latest_tick <= '0;
            r_offset      <= '0;
            r_rst_pend    <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_in.valid;
            end
            if (adv_mid) begin
                r_mid_valid <= r_in_valid;
            end
            if (step) begin
                r_sum         <= n_sum;
                r_cnt         <= n_cnt;
                r_slot        <= n_slot;
                r_bank        <= n_bank;
                r_save_pend   <= n_save_pend;
                r_rec         <= n_rec;
                r_last_fs     <= n_last_fs;
                r_latest_tick <= n_latest_tick;
                r_offset      <= n_offset;
                r_rst_pend    <= n_rst_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_in.valid) begin
            r_op   <= i_in.opcode;
            r_adc  <= i_in.adc_sample;
            r_fs   <= i_in.flight_phase;
            r_tick <= i_in.flight_tick;
        end
        if (adv_mid) begin
            r_mid <= n_mid;
        end
    end

endmodule

@@ hdl/ftsr_scale.sv @@
// Scaling stage and result register: multiply the oversampled sum, shift,
// saturate to 16 bits and hold the result beat. Depends on ftsr_pkg and ftsr_out_if.
module ftsr_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_mid_valid,
    input  ftsr_pkg::t_mid i_mid,
    input  ftsr_pkg::t_cfg i_cfg,
    output logic           o_adv,
    ftsr_out_if.source     o_out
);
    import ftsr_pkg::*;

    logic        r_out_valid;
    t_mid        r_res;
    logic [15:0] r_value;

    logic        adv_out;
    logic [47:0] product;
    logic [47:0] shifted;
    logic [15:0] n_value;

    assign adv_out = !r_out_valid || o_out.ready;
    assign o_adv   = adv_out;

    always_comb begin
        product = {16'd0, i_mid.sum} * {32'd0, i_cfg.scale_mult};
        shifted = product >> i_cfg.scale_shift;
        n_value = (|shifted[47:16]) ? 16'hFFFF : shifted[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_res   <= i_mid;
            r_value <= n_value;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.sample_ready       = r_res.sample_ready;
    assign o_out.sample_value       = r_value;
    assign o_out.sample_tick        = r_res.tick;
    assign o_out.sample_bank        = r_res.bank;
    assign o_out.sample_slot        = r_res.slot;
    assign o_out.save_request       = r_res.save_request;
    assign o_out.overrun            = r_res.overrun;
    assign o_out.record_state       = r_res.record_state;
    assign o_out.finalize_request   = r_res.finalize_request;
    assign o_out.final_sample_count = r_res.final_sample_count;
    assign o_out.reset_request      = r_res.reset_request;

endmodule

@@ hdl/flight_triggered_sample_recorder_top.sv @@
// Top level of the flight-triggered sample recorder.
// Depends on ftsr_pkg, the channel interfaces, ftsr_cfg_regs, ftsr_state and ftsr_scale.
//
// One result beat per input beat, one input beat per cycle sustained while result beats
// are taken. An item passes an input register, the state-update stage (oversampling
// sum, buffer slot and bank, recording state, file offset) and the scale stage (32x16
// multiply, shift, saturate) into the result register, from which its result beat is
// presented. Each stage advances when the next one is empty or moving, so up to two
// further input beats are taken while a finished result waits at the output.
// Configuration writes are taken in every cycle and must only be issued while no item
// is in flight.
module flight_triggered_sample_recorder_top #(
    parameter int unsigned BUFFER_ENTRIES = ftsr_pkg::BUFFER_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ftsr_in_if.sink    i_in,
    ftsr_cfg_if.sink   i_cfg,
    ftsr_out_if.source o_out
);
    import ftsr_pkg::*;

    t_cfg cfg;
    t_mid mid;
    logic mid_valid;
    logic scale_adv;

    ftsr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ftsr_state #(
        .BUFFER_ENTRIES (BUFFER_ENTRIES)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .i_next_adv  (scale_adv),
        .o_mid_valid (mid_valid),
        .o_mid       (mid)
    );

    ftsr_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .i_cfg       (cfg),
        .o_adv       (scale_adv),
        .o_out       (o_out)
    );

endmodule

@@ hdl/ftsr_checker.sv @@
// Port-level checker for the recorder and its bind to the top level.
// Depends on ftsr_pkg and flight_triggered_sample_recorder_top.
module ftsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_sample_ready,
    input logic [15:0] i_sample_value,
    input logic        i_save_request,
    input logic        i_overrun,
    input logic [1:0]  i_record_state,
    input logic        i_finalize_request,
    input logic        i_reset_request
);
    import ftsr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample_value))
        else $error("result beat changed while stalled");

    a_finalize_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_finalize_request |-> i_record_state == REC_FINALIZED)
        else $error("finalize request outside finalized state");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_reset_request |->
            i_record_state != REC_RECORDING && i_record_state != REC_FINALIZING)
        else $error("reset request while recording");

    a_save_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_save_request || i_overrun) |->
            i_sample_ready && i_save_request &&
            (i_record_state == REC_RECORDING || i_record_state == REC_FINALIZING))
        else $error("save request or overrun without a completed bank");

endmodule

bind flight_triggered_sample_recorder_top ftsr_checker u_ftsr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_sample_ready     (o_out.sample_ready),
    .i_sample_value     (o_out.sample_value),
    .i_save_request     (o_out.save_request),
    .i_overrun          (o_out.overrun),
    .i_record_state     (o_out.record_state),
    .i_finalize_request (o_out.finalize_request),
    .i_reset_request    (o_out.reset_request)
);

@@ dv/tb_flight_triggered_sample_recorder_top.sv @@
// Testbench for flight_triggered_sample_recorder_top: a directed table, then random
// flight missions under three idling modes, checked beat by beat against a predictor.
// Depends on ftsr_pkg, the three channel interfaces and the recorder RTL.
`timescale 1ns / 1ps

module tb_flight_triggered_sample_recorder_top;
    import ftsr_pkg::*;

    localparam int          BUF_DEPTH   = BUFFER_ENTRIES_DEF;
    localparam int          BUF_BYTES   = BUF_DEPTH * BYTES_PER_SAMPLE;
    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [1:0]  OP_NOP      = 2'd3;
    localparam logic [3:0]  PH_FAST     = 4'd4;
    localparam logic [3:0]  PH_INVALID  = 4'd9;
    localparam logic [3:0]  PH_CODE_MAX = 4'd15;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] adc_sample;
        logic [3:0]  flight_phase;
        logic [15:0] flight_tick;
    } t_item;

    typedef struct packed {
        logic        sample_ready;
        logic [15:0] sample_value;
        logic [15:0] sample_tick;
        logic        sample_bank;
        logic [7:0]  sample_slot;
        logic        save_request;
        logic        overrun;
        logic [1:0]  record_state;
        logic        finalize_request;
        logic [15:0] final_sample_count;
        logic        reset_request;
    } t_result;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [24:0] data;
        t_item       item;
        bit          fixed_on;
        t_result     fixed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ftsr_in_if  in_ch();
    ftsr_cfg_if cfg_ch();
    ftsr_out_if out_ch();

    flight_triggered_sample_recorder_top #(
        .BUFFER_ENTRIES(BUF_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor configuration and state
    logic [15:0] cfg_os;
    logic [15:0] cfg_mult;
    logic [4:0]  cfg_shift;
    logic [24:0] cfg_fsize;
    logic [7:0]  cfg_hdr;
    logic [31:0] acc_sum;
    logic [15:0] raw_seen;
    int unsigned slot_pos;
    logic        bank_sel;
    logic        save_outstanding;
    logic [1:0]  rec_state;
    logic [3:0]  last_fs;
    logic [15:0] stamp_tick;
    logic [24:0] file_pos;
    logic        reset_owed;

    t_result     result_queue[$];
    t_row        stim_rows[$];
    logic        row_fixed_on;
    t_result     row_fixed;

    int unsigned src_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned items_sent;
    int unsigned cycle_count;
    int unsigned err_count;
    int unsigned n_in, n_out, n_recorded, n_saves, n_overruns, n_closes;
    logic [15:0] mission_tick;

    function automatic void recorder_clear();
        cfg_os           = RST_OVERSAMPLE_COUNT;
        cfg_mult         = RST_SCALE_MULT;
        cfg_shift        = RST_SCALE_SHIFT;
        cfg_fsize        = RST_FILE_SIZE_BYTES;
        cfg_hdr          = RST_HEADER_BYTES;
        acc_sum          = '0;
        raw_seen         = '0;
        slot_pos         = 0;
        bank_sel         = 1'b0;
        save_outstanding = 1'b0;
        rec_state        = REC_READY;
        last_fs          = PH_STARTUP;
        stamp_tick       = '0;
        file_pos         = '0;
        reset_owed       = 1'b0;
    endfunction

    function automatic t_result recorder_step(t_item it);
        t_result     r;
        logic [15:0] need;
        logic [63:0] scaled;
        logic [1:0]  st;
        logic [24:0] cnt;
        r = '0;
        case (it.opcode)
            OP_RAW_SAMPLE: begin
                need = (cfg_os == 16'd0) ? 16'd1 : cfg_os;
                acc_sum  = acc_sum + 32'(it.adc_sample);
                raw_seen = raw_seen + 16'd1;
                if (raw_seen >= need) begin
                    scaled = (64'(acc_sum) * 64'(cfg_mult)) >> cfg_shift;
                    r.sample_ready = 1'b1;
                    r.sample_value = (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
                    r.sample_tick  = stamp_tick;
                    r.sample_bank  = bank_sel;
                    r.sample_slot  = slot_pos[7:0];
                    acc_sum  = '0;
                    raw_seen = '0;
                    if (slot_pos == BUF_DEPTH - 1) begin
                        slot_pos = 0;
                        bank_sel = ~bank_sel;
                        if (rec_state == REC_RECORDING || rec_state == REC_FINALIZING) begin
                            r.overrun        = save_outstanding;
                            r.save_request   = 1'b1;
                            save_outstanding = 1'b1;
                        end
                    end else begin
                        slot_pos++;
                    end
                end
            end
            OP_FLIGHT: begin
                stamp_tick = it.flight_tick;
                if (it.flight_phase != last_fs) begin
                    if (it.flight_phase == PH_STARTUP) begin
                        reset_owed = 1'b1;
                    end else if (it.flight_phase == PH_IDLE || it.flight_phase == PH_PAD) begin
                        rec_state = REC_READY;
                    end else if (it.flight_phase == PH_BOOST) begin
                        if (last_fs == PH_PAD && rec_state == REC_READY)
                            rec_state = REC_RECORDING;
                    end else if (it.flight_phase <= PH_LANDED) begin
                        if (rec_state == REC_RECORDING)
                            rec_state = REC_FINALIZING;
                    end
                end
                last_fs = it.flight_phase;
            end
            OP_SAVE_DONE: begin
                if (save_outstanding) begin
                    st = rec_state;
                    save_outstanding = 1'b0;
                    if (64'(file_pos) + BUF_BYTES <= 64'(cfg_fsize))
                        file_pos = file_pos + 25'(BUF_BYTES);
                    if (st == REC_FINALIZING) begin
                        cnt = (file_pos >= 25'(cfg_hdr)) ? (file_pos - 25'(cfg_hdr)) >> 2 : '0;
                        r.finalize_request   = 1'b1;
                        r.final_sample_count = cnt[15:0];
                        rec_state = REC_FINALIZED;
                    end else if (st == REC_RECORDING &&
                                 64'(file_pos) + BUF_BYTES >= 64'(cfg_fsize)) begin
                        rec_state = REC_FINALIZING;
                    end
                end
            end
            default: ;
        endcase
        r.record_state  = rec_state;
        r.reset_request = reset_owed && rec_state != REC_RECORDING &&
                          rec_state != REC_FINALIZING;
        return r;
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0d] %s", cycle_count, msg);
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        t_result pred;
        t_item   it;
        if (!i_rst_n) begin
            recorder_clear();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.sample_ready       = out_ch.sample_ready;
                got.sample_value       = out_ch.sample_value;
                got.sample_tick        = out_ch.sample_tick;
                got.sample_bank        = out_ch.sample_bank;
                got.sample_slot        = out_ch.sample_slot;
                got.save_request       = out_ch.save_request;
                got.overrun            = out_ch.overrun;
                got.record_state       = out_ch.record_state;
                got.finalize_request   = out_ch.finalize_request;
                got.final_sample_count = out_ch.final_sample_count;
                got.reset_request      = out_ch.reset_request;
                n_out++;
                if (result_queue.size() == 0) begin
                    note_error($sformatf("result beat with nothing expected: %p", got));
                end else begin
                    want = result_queue.pop_front();
                    if (got !== want)
                        note_error($sformatf("mismatch: expected %p, got %p", want, got));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_OVERSAMPLE_COUNT: cfg_os    = cfg_ch.data[15:0];
                    CFG_SCALE_MULT:       cfg_mult  = cfg_ch.data[15:0];
                    CFG_SCALE_SHIFT:      cfg_shift = cfg_ch.data[4:0];
                    CFG_FILE_SIZE_BYTES:  cfg_fsize = cfg_ch.data[24:0];
                    CFG_HEADER_BYTES:     cfg_hdr   = cfg_ch.data[7:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                it.opcode       = in_ch.opcode;
                it.adc_sample   = in_ch.adc_sample;
                it.flight_phase = in_ch.flight_phase;
                it.flight_tick  = in_ch.flight_tick;
                pred = recorder_step(it);
                n_in++;
                n_recorded += pred.sample_ready;
                n_saves    += pred.save_request;
                n_overruns += pred.overrun;
                n_closes   += pred.finalize_request;
                result_queue.push_back(row_fixed_on ? row_fixed : pred);
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic push_item(input t_item it, input bit fixed_on, input t_result fixed_res);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < src_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= it.opcode;
        in_ch.adc_sample   <= it.adc_sample;
        in_ch.flight_phase <= it.flight_phase;
        in_ch.flight_tick  <= it.flight_tick;
        row_fixed_on       <= fixed_on;
        row_fixed          <= fixed_res;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (it.opcode != OP_NOP)
            items_sent++;
    endtask

    task automatic send(input logic [1:0] op, input logic [11:0] adc,
                        input logic [3:0] fs, input logic [15:0] tick);
        t_item it;
        it.opcode       = op;
        it.adc_sample   = adc;
        it.flight_phase = fs;
        it.flight_tick  = tick;
        push_item(it, 1'b0, '0);
    endtask

    task automatic send_noise();
        send(2'($urandom_range(3, 0)), 12'($urandom_range(4095, 0)),
             4'($urandom_range(PH_CODE_MAX, 0)), 16'($urandom_range(65535, 0)));
    endtask

    // hold input low until every expected beat has come back
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (result_queue.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [24:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_phase(input int unsigned os, input int unsigned mult,
                             input int unsigned shift, input int unsigned fsize,
                             input int unsigned hdr);
        settle();
        cfg_write(CFG_OVERSAMPLE_COUNT, 25'(os));
        cfg_write(CFG_SCALE_MULT, 25'(mult));
        cfg_write(CFG_SCALE_SHIFT, 25'(shift));
        cfg_write(CFG_FILE_SIZE_BYTES, 25'(fsize));
        cfg_write(CFG_HEADER_BYTES, 25'(hdr));
    endtask

    function automatic logic [15:0] next_tick();
        mission_tick = mission_tick + 16'($urandom_range(500, 1));
        return mission_tick;
    endfunction

    function automatic logic [11:0] pick_adc();
        case ($urandom_range(9, 0))
            0:       return 12'h000;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(4095, 0));
        endcase
    endfunction

    function automatic int unsigned clip_len(input int unsigned want,
                                             input int unsigned stop_at);
        if (items_sent >= stop_at)
            return 0;
        return (stop_at - items_sent < want) ? stop_at - items_sent : want;
    endfunction

    task automatic sample_burst(input int unsigned len, input int unsigned save_pct);
        int unsigned r;
        repeat (len) begin
            r = $urandom_range(99, 0);
            if (r < save_pct)
                send(OP_SAVE_DONE, pick_adc(), 4'($urandom_range(PH_CODE_MAX, 0)), next_tick());
            else if (r < save_pct + 2)
                send_noise();
            else
                send(OP_RAW_SAMPLE, pick_adc(), 4'($urandom_range(PH_CODE_MAX, 0)),
                     16'($urandom_range(65535, 0)));
        end
    endtask

    // idle, pad, boost, burst, descend, burst, optional save-done tail and startup; or a noise run
    task automatic fly_mission(input int unsigned budget);
        int unsigned start_cnt;
        int unsigned stop_at;
        int unsigned save_pct;
        start_cnt = items_sent;
        stop_at   = start_cnt + budget;
        while (items_sent - start_cnt < budget) begin
            if ($urandom_range(99, 0) < 75) begin
                case ($urandom_range(2, 0))
                    0:       save_pct = 0;
                    1:       save_pct = 1;
                    default: save_pct = 4;
                endcase
                send(OP_FLIGHT, pick_adc(), PH_IDLE, next_tick());
                send(OP_FLIGHT, pick_adc(), PH_PAD, next_tick());
                send(OP_FLIGHT, pick_adc(), PH_BOOST, next_tick());
                sample_burst(clip_len($urandom_range(300, 20), stop_at), save_pct);
                send(OP_FLIGHT, pick_adc(), 4'($urandom_range(PH_LANDED, PH_FAST)), next_tick());
                sample_burst(clip_len($urandom_range(200, 0), stop_at), save_pct);
                if (save_pct != 0 || $urandom_range(1, 0) == 1)
                    repeat ($urandom_range(3, 1))
                        send(OP_SAVE_DONE, pick_adc(), PH_LANDED, next_tick());
                if ($urandom_range(9, 0) == 0)
                    send(OP_FLIGHT, pick_adc(), PH_STARTUP, next_tick());
            end else begin
                repeat ($urandom_range(30, 5)) send_noise();
            end
        end
    endtask

    function automatic void add_item_row(input logic [1:0] op, input logic [11:0] adc,
                                         input logic [3:0] fs, input logic [15:0] tick,
                                         input bit fixed_on, input t_result fixed_res);
        t_row row;
        row.is_cfg            = 1'b0;
        row.idx               = '0;
        row.data              = '0;
        row.item.opcode       = op;
        row.item.adc_sample   = adc;
        row.item.flight_phase = fs;
        row.item.flight_tick  = tick;
        row.fixed_on          = fixed_on;
        row.fixed             = fixed_res;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(input logic [2:0] idx, input logic [24:0] data);
        t_row row;
        row.is_cfg   = 1'b1;
        row.idx      = idx;
        row.data     = data;
        row.item     = '0;
        row.fixed_on = 1'b0;
        row.fixed    = '0;
        stim_rows.push_back(row);
    endfunction

    initial begin : stimulus
        t_result zero_res;
        t_result sat_res;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_NOP;
        in_ch.adc_sample   = '0;
        in_ch.flight_phase = PH_STARTUP;
        in_ch.flight_tick  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_OVERSAMPLE_COUNT;
        cfg_ch.data        = '0;
        row_fixed_on       = 1'b0;
        row_fixed          = '0;
        src_gap_pct        = 18;
        sink_stall_pct     = 88;
        items_sent         = 0;
        err_count          = 0;
        mission_tick       = '0;
        n_in = 0; n_out = 0; n_recorded = 0; n_saves = 0; n_overruns = 0; n_closes = 0;

        zero_res = '0;
        sat_res  = '0;
        sat_res.sample_ready = 1'b1;
        sat_res.sample_value = 16'hFFFF;
        sat_res.sample_tick  = 16'hFFFF;

        add_item_row(OP_NOP, 12'h000, PH_STARTUP, 16'h0000, 1'b1, zero_res);
        add_item_row(OP_RAW_SAMPLE, 12'hFFF, PH_STARTUP, 16'h0000, 1'b1, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_STARTUP, 16'hFFFF, 1'b0, zero_res);
        add_item_row(OP_SAVE_DONE, 12'h000, PH_STARTUP, 16'h0000, 1'b1, zero_res);
        add_cfg_row(CFG_OVERSAMPLE_COUNT, 25'd0);
        add_cfg_row(CFG_SCALE_MULT, 25'd65535);
        add_cfg_row(CFG_SCALE_SHIFT, 25'd0);
        add_cfg_row(CFG_FILE_SIZE_BYTES, 25'd16777216);
        add_cfg_row(CFG_HEADER_BYTES, 25'd255);
        add_item_row(OP_RAW_SAMPLE, 12'hFFF, PH_STARTUP, 16'h0000, 1'b1, sat_res);
        add_item_row(OP_RAW_SAMPLE, 12'h000, PH_CODE_MAX, 16'hFFFF, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'hFFF, PH_IDLE, 16'h0000, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_PAD, 16'h1234, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_BOOST, 16'h8000, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_INVALID, 16'h8001, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_CODE_MAX, 16'h8002, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_BOOST, 16'h8003, 1'b0, zero_res);
        add_cfg_row(CFG_SCALE_SHIFT, 25'd31);
        add_item_row(OP_RAW_SAMPLE, 12'hFFF, PH_STARTUP, 16'h0000, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_FAST, 16'h9000, 1'b0, zero_res);
        add_item_row(OP_SAVE_DONE, 12'h000, PH_STARTUP, 16'h0000, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_STARTUP, 16'h9001, 1'b0, zero_res);
        add_item_row(OP_FLIGHT, 12'h000, PH_IDLE, 16'h9002, 1'b0, zero_res);
        add_item_row(OP_NOP, 12'hFFF, PH_CODE_MAX, 16'hFFFF, 1'b0, zero_res);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                settle();
                cfg_write(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                push_item(stim_rows[i].item, stim_rows[i].fixed_on, stim_rows[i].fixed);
            end
        end

        set_phase(0, 65535, 0, 0, 255);
        fly_mission(280);

        src_gap_pct    = 88;
        sink_stall_pct = 18;
        set_phase(1, $urandom_range(65535, 1), $urandom_range(24, 8), 3072,
                  $urandom_range(255, 0));
        fly_mission(280);
        set_phase(65535, 0, 31, 16777216, 255);
        sample_burst(40, 0);

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        set_phase(1, $urandom_range(65535, 0), $urandom_range(20, 12), 16777216,
                  $urandom_range(255, 0));
        fly_mission(150);
        settle();
        fly_mission(150);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (result_queue.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);

        $display("Recorder run: %0d item beats, %0d result beats in %0d cycles",
                 n_in, n_out, cycle_count);
        $display("  %0d samples, %0d save requests, %0d overruns, %0d file closes, %0d errors",
                 n_recorded, n_saves, n_overruns, n_closes, err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
